[src/gbpp_pkg.sv]
// Package for the grid binned point picker: sizes, codes, request and
// response structs, and the controller/datapath command and status structs.
// No dependencies.
package gbpp_pkg;

  localparam int MAX_COLS = 256;
  localparam int MAX_ROWS = 256;
  localparam int ID_BITS  = 24;

  localparam int COL_BITS   = $clog2(MAX_COLS);
  localparam int ROW_BITS   = $clog2(MAX_ROWS);
  localparam int ADDR_BITS  = COL_BITS + ROW_BITS;
  localparam int CELL_DEPTH = 1 << ADDR_BITS;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam int COL_DIM_W  = $clog2(MAX_COLS + 1);
  localparam int ROW_DIM_W  = $clog2(MAX_ROWS + 1);
  localparam int GRID_DIM_W = (COL_DIM_W > ROW_DIM_W) ? COL_DIM_W : ROW_DIM_W;
  localparam int DIM_W      = (GRID_DIM_W > CFG_DATA_W) ? GRID_DIM_W : CFG_DATA_W;
  localparam int WIN_W      = DIM_W + 2;

  typedef logic [ID_BITS-1:0]       id_t;
  typedef logic [23:0]              pid_t;
  typedef logic [ADDR_BITS-1:0]     addr_t;
  typedef logic [DIM_W-1:0]         dim_t;
  typedef logic signed [WIN_W-1:0]  win_t;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CELL_SHIFT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_COLS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_ROWS   = 3'd4;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    pid_t               point_id;
  } in_req_t;

  typedef struct packed {
    logic               found;
    pid_t               hit_id;
    logic               in_view;
    logic [7:0]         bin_count;
    logic               box_valid;
    logic signed [15:0] box_min_x;
    logic signed [15:0] box_min_y;
    logic signed [15:0] box_max_x;
    logic signed [15:0] box_max_y;
  } out_rsp_t;

  typedef struct packed {
    logic load;
    logic box_clear;
    logic sweep_en;
    logic probe_init;
    logic probe_issue;
    logic ins_write;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       cell_in_grid;
    logic       query_ok;
    logic       sweep_last;
    logic       probe_last;
    logic       hit;
    logic       out_free;
  } dp_status_t;

endpackage

[src/gbpp_ctrl.sv]
// Controller state machine of the grid binned point picker.
// Depends on gbpp_pkg for the command and status structs and the func codes.
module gbpp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  gbpp_pkg::dp_status_t  status,
  output gbpp_pkg::dp_cmd_t     cmd
);

  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_DECODE = 8'b0000_0100,
    S_SWEEP  = 8'b0000_1000,
    S_INS_WR = 8'b0001_0000,
    S_PROBE  = 8'b0010_0000,
    S_DRAIN  = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_INIT: begin
        cmd.sweep_en = 1'b1;
        if (status.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status.func)
          gbpp_pkg::FUNC_CLEAR: begin
            cmd.box_clear = 1'b1;
            state_next    = S_SWEEP;
          end
          gbpp_pkg::FUNC_INSERT: begin
            state_next = status.cell_in_grid ? S_INS_WR : S_FINISH;
          end
          gbpp_pkg::FUNC_QUERY: begin
            cmd.probe_init = 1'b1;
            state_next     = status.query_ok ? S_PROBE : S_FINISH;
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_SWEEP: begin
        cmd.sweep_en = 1'b1;
        if (status.sweep_last) state_next = S_FINISH;
      end
      S_INS_WR: begin
        cmd.ins_write = 1'b1;
        state_next    = S_FINISH;
      end
      S_PROBE: begin
        cmd.probe_issue = 1'b1;
        if (status.hit) begin
          state_next = S_FINISH;
        end else if (status.probe_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

endmodule

[src/gbpp_dp.sv]
// Datapath of the grid binned point picker: configuration registers, cell
// binning, count and id memories, probe walker, bounding box, result register.
// Depends on gbpp_pkg.
module gbpp_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  gbpp_pkg::in_req_t                   in_data,
  input  logic                                out_stall,
  output logic                                out_valid,
  output gbpp_pkg::out_rsp_t                  out_data,
  input  logic                                cfg_write,
  input  logic [gbpp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gbpp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  gbpp_pkg::dp_cmd_t                   cmd,
  output gbpp_pkg::dp_status_t                status
);

  localparam int COL_BITS = gbpp_pkg::COL_BITS;
  localparam int ROW_BITS = gbpp_pkg::ROW_BITS;
  localparam int DIM_W    = gbpp_pkg::DIM_W;
  localparam int WIN_W    = gbpp_pkg::WIN_W;

  function automatic logic signed [15:0] to_cell(input logic signed [15:0] p,
                                                 input logic [2:0] s);
    logic [16:0] mag;
    logic [16:0] sh;
    mag = p[15] ? (17'd0 - {p[15], p}) : {1'b0, p};
    sh  = mag >> s;
    to_cell = p[15] ? 16'(17'd0 - sh) : sh[15:0];
  endfunction

  // Configuration registers
  logic [2:0] cell_shift;
  logic [8:0] grid_cols;
  logic [8:0] grid_rows;
  logic [3:0] half_cols;
  logic [3:0] half_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_shift <= 3'd0;
      grid_cols  <= 9'd256;
      grid_rows  <= 9'd256;
      half_cols  <= 4'd1;
      half_rows  <= 4'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        gbpp_pkg::REG_CELL_SHIFT: cell_shift <= cfg_data[2:0];
        gbpp_pkg::REG_GRID_COLS:  grid_cols  <= cfg_data[8:0];
        gbpp_pkg::REG_GRID_ROWS:  grid_rows  <= cfg_data[8:0];
        gbpp_pkg::REG_HALF_COLS:  half_cols  <= cfg_data[3:0];
        gbpp_pkg::REG_HALF_ROWS:  half_rows  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  gbpp_pkg::dim_t cols_used, rows_used;

  always_comb begin
    if (gbpp_pkg::dim_t'(grid_cols) > gbpp_pkg::dim_t'(gbpp_pkg::MAX_COLS)) begin
      cols_used = gbpp_pkg::dim_t'(gbpp_pkg::MAX_COLS);
    end else begin
      cols_used = gbpp_pkg::dim_t'(grid_cols);
    end
    if (gbpp_pkg::dim_t'(grid_rows) > gbpp_pkg::dim_t'(gbpp_pkg::MAX_ROWS)) begin
      rows_used = gbpp_pkg::dim_t'(gbpp_pkg::MAX_ROWS);
    end else begin
      rows_used = gbpp_pkg::dim_t'(grid_rows);
    end
  end

  // Request register
  gbpp_pkg::in_req_t req_q;

  always_ff @(posedge clk) begin
    if (cmd.load) req_q <= in_data;
  end

  // Cell of the request
  logic signed [15:0] cell_c, cell_r;
  logic               cell_in_grid, query_ok;
  gbpp_pkg::addr_t    cell_addr;

  assign cell_c = to_cell(req_q.pos_x, cell_shift);
  assign cell_r = to_cell(req_q.pos_y, cell_shift);

  assign cell_in_grid = !cell_c[15] && !cell_r[15] &&
                        (cell_c[14:0] < 15'(cols_used)) && (cell_r[14:0] < 15'(rows_used));
  assign query_ok     = !cell_c[15] && !cell_r[15] &&
                        (cell_c[14:0] <= 15'(cols_used)) && (cell_r[14:0] <= 15'(rows_used));
  assign cell_addr    = {cell_c[COL_BITS-1:0], cell_r[ROW_BITS-1:0]};

  // Window bounds around the centre cell
  gbpp_pkg::win_t cen_x, cen_y, x_lo, x_hi, y_lo, y_hi;
  logic           halves_zero;

  assign cen_x = gbpp_pkg::win_t'({1'b0, cell_c[DIM_W-1:0]});
  assign cen_y = gbpp_pkg::win_t'({1'b0, cell_r[DIM_W-1:0]});
  assign x_lo  = gbpp_pkg::win_t'(cen_x - gbpp_pkg::win_t'(half_cols));
  assign x_hi  = gbpp_pkg::win_t'(cen_x + gbpp_pkg::win_t'(half_cols));
  assign y_lo  = gbpp_pkg::win_t'(cen_y - gbpp_pkg::win_t'(half_rows));
  assign y_hi  = gbpp_pkg::win_t'(cen_y + gbpp_pkg::win_t'(half_rows));
  assign halves_zero = (half_cols == 4'd0) || (half_rows == 4'd0);

  // Probe walker: centre first, then the window column by column
  gbpp_pkg::win_t  pr_x, pr_y;
  logic            pr_win;
  logic            probe_in_grid, probe_last;
  gbpp_pkg::addr_t probe_addr;

  assign probe_in_grid = !pr_x[WIN_W-1] && !pr_y[WIN_W-1] &&
                         (pr_x[WIN_W-2:0] < {1'b0, cols_used}) &&
                         (pr_y[WIN_W-2:0] < {1'b0, rows_used});
  assign probe_addr    = {pr_x[COL_BITS-1:0], pr_y[ROW_BITS-1:0]};
  assign probe_last    = pr_win ? ((pr_x == x_hi) && (pr_y == y_hi)) : halves_zero;

  always_ff @(posedge clk) begin
    if (cmd.probe_init) begin
      pr_x   <= cen_x;
      pr_y   <= cen_y;
      pr_win <= 1'b0;
    end else if (cmd.probe_issue) begin
      if (!pr_win) begin
        pr_x   <= x_lo;
        pr_y   <= y_lo;
        pr_win <= 1'b1;
      end else if (pr_y != y_hi) begin
        pr_y <= gbpp_pkg::win_t'(pr_y + 1'b1);
      end else begin
        pr_x <= gbpp_pkg::win_t'(pr_x + 1'b1);
        pr_y <= y_lo;
      end
    end
  end

  // Clearing sweep counter
  gbpp_pkg::addr_t sweep_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (cmd.sweep_en) begin
      sweep_addr <= gbpp_pkg::addr_t'(sweep_addr + 1'b1);
    end
  end

  // Count and id memories
  logic [7:0]        count_mem [gbpp_pkg::CELL_DEPTH];
  gbpp_pkg::id_t     id_mem    [gbpp_pkg::CELL_DEPTH];
  gbpp_pkg::addr_t   rd_addr;
  logic [7:0]        count_rd, count_new;
  gbpp_pkg::id_t     id_rd;

  assign rd_addr = cmd.probe_issue ? probe_addr : cell_addr;

  always_ff @(posedge clk) begin
    count_rd <= count_mem[rd_addr];
    id_rd    <= id_mem[rd_addr];
  end

  always_comb begin
    if (count_rd == 8'd0) begin
      count_new = 8'd1;
    end else if (count_rd == 8'hFF) begin
      count_new = 8'hFF;
    end else begin
      count_new = 8'(count_rd + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_en) begin
      count_mem[sweep_addr] <= 8'd0;
    end else if (cmd.ins_write) begin
      count_mem[cell_addr] <= count_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_write && (count_rd == 8'd0)) begin
      id_mem[cell_addr] <= gbpp_pkg::id_t'(req_q.point_id);
    end
  end

  // Probe read in flight
  logic rd_vld, rd_ok, hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.probe_issue;
    end
    rd_ok <= probe_in_grid;
  end

  assign hit = rd_vld && rd_ok && (count_rd == 8'd1);

  // Result staging
  logic          res_found, res_in_view;
  gbpp_pkg::id_t res_hit;
  logic [7:0]    res_count;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_found   <= 1'b0;
      res_hit     <= '0;
      res_in_view <= 1'b0;
      res_count   <= 8'd0;
    end else if (cmd.ins_write) begin
      res_in_view <= 1'b1;
      res_count   <= count_new;
      res_found   <= (count_rd == 8'd0);
    end else if (hit && !res_found) begin
      res_found <= 1'b1;
      res_hit   <= id_rd;
    end
  end

  // Bounding box
  logic               box_has;
  logic signed [15:0] box_lo_x, box_lo_y, box_hi_x, box_hi_y;

  always_ff @(posedge clk) begin
    if (rst || cmd.box_clear) begin
      box_has  <= 1'b0;
      box_lo_x <= '0;
      box_lo_y <= '0;
      box_hi_x <= '0;
      box_hi_y <= '0;
    end else if (cmd.ins_write && (count_rd == 8'd0)) begin
      box_has <= 1'b1;
      if (!box_has) begin
        box_lo_x <= req_q.pos_x;
        box_hi_x <= req_q.pos_x;
        box_lo_y <= req_q.pos_y;
        box_hi_y <= req_q.pos_y;
      end else begin
        if (req_q.pos_x < box_lo_x) box_lo_x <= req_q.pos_x;
        if (req_q.pos_y < box_lo_y) box_lo_y <= req_q.pos_y;
        if (req_q.pos_x > box_hi_x) box_hi_x <= req_q.pos_x;
        if (req_q.pos_y > box_hi_y) box_hi_y <= req_q.pos_y;
      end
    end
  end

  // Output register
  logic               out_valid_q;
  gbpp_pkg::out_rsp_t out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_q.found     <= res_found;
      out_q.hit_id    <= gbpp_pkg::pid_t'(res_hit);
      out_q.in_view   <= res_in_view;
      out_q.bin_count <= res_count;
      out_q.box_valid <= box_has;
      out_q.box_min_x <= box_lo_x;
      out_q.box_min_y <= box_lo_y;
      out_q.box_max_x <= box_hi_x;
      out_q.box_max_y <= box_hi_y;
    end
  end

  assign out_valid = out_valid_q;
  assign out_data  = out_q;

  assign status.func         = req_q.func;
  assign status.cell_in_grid = cell_in_grid;
  assign status.query_ok     = query_ok;
  assign status.sweep_last   = &sweep_addr;
  assign status.probe_last   = probe_last;
  assign status.hit          = hit;
  assign status.out_free     = !out_valid_q || !out_stall;

endmodule

[src/grid_binned_point_picker_core.sv]
// Per request: an insert reads then writes its cell; func 3 and an insert or query whose
// cell is out of range go straight to the result; a query makes P probes (centre plus
// up to (2*hc+1)*(2*hr+1) cells, one memory read a probe, stopping at the first single-point
// cell); a clear sweeps all 2^(COL_BITS+ROW_BITS) counts (65536 at 256 x 256).
// One request in work at a time; the next is taken in the cycle after the last result loads.
// Reset (rst, synchronous) runs a count sweep over every cell; in_stall stays high until done.
//
// Grid binned point picker: uniform grid of cells holding point ids and
// saturating counts, with a bounding box of stored points and a window query.
// Depends on gbpp_pkg, gbpp_ctrl and gbpp_dp.
module grid_binned_point_picker_core (
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  gbpp_pkg::in_req_t                 in_data,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output gbpp_pkg::out_rsp_t                out_data,
  // configuration writes, to be made only while idle; the block does not enforce it
  input  logic                              cfg_write,
  input  logic [gbpp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gbpp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // The controller sequences each request through decode, then one of: clear sweep,
  // cell read-modify-write or probe walk (none for func 3 or an out-of-range cell). The
  // datapath holds all storage; the two talk only through cmd and status.
  gbpp_pkg::dp_cmd_t    cmd;
  gbpp_pkg::dp_status_t status;

  gbpp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Counts live in a memory swept to zero on reset and on clear; ids are
  // written only when a cell takes its first point and are never cleared.
  gbpp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

[src/gbpp_checker.sv]
// Port-level checker for the grid binned point picker, bound to the top level.
// Depends on gbpp_pkg and grid_binned_point_picker_core.
module gbpp_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input gbpp_pkg::out_rsp_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_empty_box: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.box_valid |->
      (out_data.box_min_x == 16'sd0) && (out_data.box_min_y == 16'sd0) &&
      (out_data.box_max_x == 16'sd0) && (out_data.box_max_y == 16'sd0))
    else $error("empty box reports nonzero bounds");

  a_out_of_view: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.in_view |-> (out_data.bin_count == 8'd0))
    else $error("count reported without an in-view insert");

  a_stored_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.in_view && out_data.found |->
      (out_data.bin_count == 8'd1) && out_data.box_valid)
    else $error("stored insert without count one and a valid box");

  a_no_hit_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> (out_data.hit_id == '0))
    else $error("hit id set without a hit");

endmodule

bind grid_binned_point_picker_core gbpp_checker u_gbpp_checker (.*);

[tb/grid_binned_point_picker_core_test.sv]
// Self-checking testbench for grid_binned_point_picker_core: directed and random
// insert, query and clear requests checked against a grid tracker class.
// Depends on gbpp_pkg and the grid_binned_point_picker_core RTL.
module grid_binned_point_picker_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gbpp_pkg::*;

  localparam int HALF_PERIOD   = 2;
  localparam int CLK_PERIOD    = 2 * HALF_PERIOD;
  localparam int RESET_CYCLES  = 8;
  // Time for an insert or the unused code to settle; leave some margin.
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  // The worst case comes from the full clears and the reset sweep, the largest windows,
  // and the longest gaps on both sides.
  localparam int LIMIT_CYCLES  = 4_000_000;
  localparam int LONG_HOLD     = 400;

  // The func code that the block leaves without effect.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Tracks cell counts, cell ids and the bounding box, and holds the results
  // still owed by the block, oldest first.
  class point_grid_tracker;
    byte unsigned cell_count [CELL_DEPTH];
    pid_t         cell_id    [CELL_DEPTH];
    bit           box_live;
    int           box_lo_x, box_lo_y, box_hi_x, box_hi_y;
    int unsigned  shift, cols, rows, half_cols, half_rows;
    pid_t         probe_id;
    out_rsp_t     awaited [$];
    int           errors;

    function new();
      wipe_grid();
      foreach (cell_id[k]) cell_id[k] = '0;
      shift     = 0;
      cols      = 256;
      rows      = 256;
      half_cols = 1;
      half_rows = 1;
      errors    = 0;
    endfunction

    function void wipe_grid();
      foreach (cell_count[k]) cell_count[k] = 8'd0;
      box_live = 1'b0;
      box_lo_x = 0;
      box_lo_y = 0;
      box_hi_x = 0;
      box_hi_y = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
      case (idx)
        REG_CELL_SHIFT: shift     = val & 32'h7;
        REG_GRID_COLS:  cols      = val & 32'h1FF;
        REG_GRID_ROWS:  rows      = val & 32'h1FF;
        REG_HALF_COLS:  half_cols = val & 32'hF;
        REG_HALF_ROWS:  half_rows = val & 32'hF;
        default: ;
      endcase
    endfunction

    function int cols_used();
      return (cols > MAX_COLS) ? MAX_COLS : cols;
    endfunction

    function int rows_used();
      return (rows > MAX_ROWS) ? MAX_ROWS : rows;
    endfunction

    // Truncate toward zero, so small negative positions fall into cell zero.
    function int to_cell(logic signed [15:0] p);
      int v;
      v = int'(p);
      if (v >= 0) return v >> shift;
      return -((-v) >> shift);
    endfunction

    function bit in_grid(int c, int r);
      return c >= 0 && r >= 0 && c < cols_used() && r < rows_used();
    endfunction

    function bit single_at(int c, int r);
      int k;
      if (!in_grid(c, r)) return 1'b0;
      k = c * MAX_ROWS + r;
      if (cell_count[k] != 8'd1) return 1'b0;
      probe_id = cell_id[k];
      return 1'b1;
    endfunction

    function void take_request(in_req_t req);
      out_rsp_t rsp;
      int       c, r, k, px, py, xi, yi;
      bit       hit;
      rsp = '0;
      c   = to_cell(req.pos_x);
      r   = to_cell(req.pos_y);
      px  = int'(req.pos_x);
      py  = int'(req.pos_y);
      case (req.func)
        FUNC_CLEAR: wipe_grid();
        FUNC_INSERT: begin
          if (in_grid(c, r)) begin
            k = c * MAX_ROWS + r;
            rsp.in_view = 1'b1;
            if (cell_count[k] != 8'd0) begin
              if (cell_count[k] < 8'd255) cell_count[k]++;
            end else begin
              cell_count[k] = 8'd1;
              cell_id[k]    = req.point_id;
              rsp.found     = 1'b1;
              if (!box_live) begin
                box_live = 1'b1;
                box_lo_x = px;
                box_hi_x = px;
                box_lo_y = py;
                box_hi_y = py;
              end else begin
                if (px < box_lo_x) box_lo_x = px;
                if (py < box_lo_y) box_lo_y = py;
                if (px > box_hi_x) box_hi_x = px;
                if (py > box_hi_y) box_hi_y = py;
              end
            end
            rsp.bin_count = cell_count[k];
          end
        end
        FUNC_QUERY: begin
          // The centre may sit one cell past the grid; further out is a miss.
          if (c >= 0 && r >= 0 && c <= cols_used() && r <= rows_used()) begin
            hit = single_at(c, r);
            if (!hit && half_cols > 0 && half_rows > 0) begin
              for (xi = c - int'(half_cols); xi <= c + int'(half_cols) && !hit; xi++)
                for (yi = r - int'(half_rows); yi <= r + int'(half_rows) && !hit; yi++)
                  hit = single_at(xi, yi);
            end
            rsp.found  = hit;
            rsp.hit_id = hit ? probe_id : '0;
          end
        end
        default: ;
      endcase
      rsp.box_valid = box_live;
      rsp.box_min_x = box_lo_x[15:0];
      rsp.box_min_y = box_lo_y[15:0];
      rsp.box_max_x = box_hi_x[15:0];
      rsp.box_max_y = box_hi_y[15:0];
      awaited.push_back(rsp);
    endfunction

    function void compare_field(string name, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void match_response(out_rsp_t got);
      out_rsp_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result %h arrived with no request waiting", $time, got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare_field("found",     32'(want.found),     32'(got.found));
      compare_field("hit_id",    32'(want.hit_id),    32'(got.hit_id));
      compare_field("in_view",   32'(want.in_view),   32'(got.in_view));
      compare_field("bin_count", 32'(want.bin_count), 32'(got.bin_count));
      compare_field("box_valid", 32'(want.box_valid), 32'(got.box_valid));
      compare_field("box_min_x", 32'(want.box_min_x), 32'(got.box_min_x));
      compare_field("box_min_y", 32'(want.box_min_y), 32'(got.box_min_y));
      compare_field("box_max_x", 32'(want.box_max_x), 32'(got.box_max_x));
      compare_field("box_max_y", 32'(want.box_max_y), 32'(got.box_max_y));
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_req_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_rsp_t              out_data;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Shared between the request side and the result side.
  bit  no_idle      = 1'b0;
  int  hold_request = 0;

  point_grid_tracker grid = new();

  grid_binned_point_picker_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int idle_span();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic in_req_t build_request(logic [1:0] func, logic [15:0] x,
                                            logic [15:0] y, logic [23:0] id);
    in_req_t req;
    req.func     = func;
    req.pos_x    = x;
    req.pos_y    = y;
    req.point_id = id;
    return req;
  endfunction

  // Pick a coordinate from one cell below zero to one cell past the span.
  function automatic logic [15:0] pick_coord(int unsigned cells, int unsigned shift);
    int v;
    v = int'($urandom_range((cells + 2) << shift)) - (1 << shift);
    if (v > 32767) v = 32767;
    return v[15:0];
  endfunction

  // Keep most positions inside a cluster of cells near the origin, so that
  // cells fill, collide and saturate; spray a few across the whole range.
  function automatic in_req_t make_request(int unsigned shift, int unsigned cols,
                                           int unsigned rows, int insert_pct,
                                           int unsigned cluster);
    in_req_t     req;
    int          roll;
    int unsigned span_c, span_r;
    roll = $urandom_range(99);
    if (roll < 3) req.func = FUNC_UNUSED;
    else if (roll < 3 + insert_pct) req.func = FUNC_INSERT;
    else req.func = FUNC_QUERY;
    req.point_id = 24'($urandom());
    span_c = (cols > MAX_COLS) ? MAX_COLS : cols;
    span_r = (rows > MAX_ROWS) ? MAX_ROWS : rows;
    if (span_c > cluster) span_c = cluster;
    if (span_r > cluster) span_r = cluster;
    if ($urandom_range(99) < 12) begin
      req.pos_x = 16'($urandom());
      req.pos_y = 16'($urandom());
    end else begin
      req.pos_x = pick_coord(span_c, shift);
      req.pos_y = pick_coord(span_r, shift);
    end
    return req;
  endfunction

  // Offer one request after a random gap; hold it until the block takes it.
  task automatic send_request(in_req_t req);
    int gap;
    gap = no_idle ? 0 : idle_span();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    grid.take_request(req);
  endtask

  // Drop valid, drain every owed result, let the block settle, and wait
  // until it takes requests again.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (grid.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  // Write all five registers on back-to-back edges; keep the enable high
  // across the burst.
  task automatic write_regs(int unsigned shift, int unsigned cols, int unsigned rows,
                            int unsigned hc, int unsigned hr);
    logic [CFG_IDX_W-1:0] idx [5];
    int unsigned          val [5];
    int                   k;
    idx = '{REG_CELL_SHIFT, REG_GRID_COLS, REG_GRID_ROWS, REG_HALF_COLS, REG_HALF_ROWS};
    val = '{shift, cols, rows, hc, hr};
    cfg_write <= 1'b1;
    for (k = 0; k < 5; k++) begin
      cfg_index <= idx[k];
      cfg_data  <= val[k][CFG_DATA_W-1:0];
      @(posedge clk);
      grid.set_reg(idx[k], val[k]);
    end
    cfg_write <= 1'b0;
  endtask

  // One random phase under one register setting. Optionally start with a
  // clear; without it, stale cells from the previous grid stay behind.
  task automatic run_phase(int unsigned shift, int unsigned cols, int unsigned rows,
                           int unsigned hc, int unsigned hr, int items, bit wipe,
                           int insert_pct, int unsigned cluster, bit squeeze);
    int n;
    wait_quiet();
    write_regs(shift, cols, rows, hc, hr);
    if (wipe) send_request(build_request(FUNC_CLEAR, 16'($urandom()), 16'($urandom()),
                                         24'($urandom())));
    for (n = 0; n < items; n++) begin
      // Run a stretch back to back on both sides.
      no_idle = (n >= 40 && n < 70);
      // Hold the result side off while requests keep coming, so the block
      // fills up and stalls its input.
      if (squeeze && n == 20) hold_request = LONG_HOLD;
      // Pause the request side until every owed result has come back.
      if (squeeze && n == items / 2) wait_quiet();
      send_request(make_request(shift, cols, rows, insert_pct, cluster));
    end
    no_idle = 1'b0;
  endtask

  // Result side: check every accepted result, then choose the next stall.
  initial begin : result_side
    int run_left;
    int hold_left;
    bit hold_on;
    run_left  = 0;
    hold_left = 0;
    hold_on   = 1'b0;
    forever begin
      @(posedge clk);
      if (rst == 1'b0 && out_valid === 1'b1 && out_stall == 1'b0)
        grid.match_response(out_data);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (no_idle) begin
        out_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          hold_on  = ($urandom_range(2) == 0);
          run_left = hold_on ? idle_span() : $urandom_range(10, 1);
          if (run_left == 0) begin
            hold_on  = 1'b0;
            run_left = 1;
          end
        end
        run_left--;
        out_stall <= hold_on;
      end
    end
  end

  // Request side and the end of the run.
  initial begin : request_side
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    // Wait out the count sweep that follows reset.
    do @(posedge clk); while (in_stall !== 1'b0);

    // Directed part under the reset setting: 1 px cells, 256 x 256, window 3 x 3.
    send_request(build_request(FUNC_QUERY,  16'd0, 16'd0, 24'd0));        // empty grid
    send_request(build_request(FUNC_INSERT, 16'd0, 16'd0, 24'hFFFFFF));   // first point
    send_request(build_request(FUNC_INSERT, 16'd0, 16'd0, 24'h000005));   // occupied cell
    send_request(build_request(FUNC_INSERT, 16'd1, 16'd1, 24'h123456));
    send_request(build_request(FUNC_QUERY,  16'd0, 16'd0, 24'd0));        // hit by scan
    send_request(build_request(FUNC_INSERT, 16'd256, 16'd0, 24'h0000AA)); // past last column
    send_request(build_request(FUNC_INSERT, -16'sd1, 16'd5, 24'h0000BB)); // negative column
    send_request(build_request(FUNC_INSERT, 16'h8000, 16'h7FFF, 24'h0000CC));
    send_request(build_request(FUNC_INSERT, 16'd255, 16'd255, 24'd0));   // far corner
    send_request(build_request(FUNC_QUERY,  16'd256, 16'd256, 24'd0));    // one cell past
    send_request(build_request(FUNC_QUERY,  16'd257, 16'd3, 24'd0));      // too far out
    send_request(build_request(FUNC_QUERY,  -16'sd1, 16'd0, 24'd0));      // negative cell
    send_request(build_request(FUNC_QUERY,  16'h7FFF, 16'h8000, 24'd0));
    send_request(build_request(FUNC_UNUSED, 16'd1234, -16'sd4321, 24'hABCDEF));
    send_request(build_request(FUNC_CLEAR,  16'd0, 16'd0, 24'd0));
    send_request(build_request(FUNC_QUERY,  16'd255, 16'd255, 24'd0));    // after clear

    // Largest cells, column count above its maximum, two rows, zero half width.
    wait_quiet();
    write_regs(7, 511, 2, 0, 15);
    send_request(build_request(FUNC_INSERT, -16'sd100, -16'sd127, 24'h00A5A5)); // cell zero
    send_request(build_request(FUNC_QUERY,  -16'sd5, -16'sd5, 24'd0));
    send_request(build_request(FUNC_INSERT, 16'h7FFF, 16'd200, 24'h5A5A5A));
    send_request(build_request(FUNC_INSERT, 16'h7FFF, 16'd255, 24'h000777));
    send_request(build_request(FUNC_QUERY,  16'h7FFF, 16'd256, 24'd0));   // row one past
    send_request(build_request(FUNC_QUERY,  16'd0, 16'd130, 24'd0));      // centre only
    send_request(build_request(FUNC_INSERT, 16'd127, 16'h8000, 24'h000999));

    // Random phases: shift, cols, rows, half cols, half rows, requests, clear,
    // insert share, cluster size in cells, back pressure.
    run_phase(0, 256, 256,  1,  1, 300, 1'b1, 55, 12, 1'b0);
    run_phase(3,  40,  30,  3,  2, 400, 1'b0, 50,  8, 1'b1);
    run_phase(7,   1,   1,  2,  2, 400, 1'b1, 92,  0, 1'b0); // drive one cell to 255
    run_phase(5, 511,   8,  0,  3, 300, 1'b0, 50,  6, 1'b0);
    run_phase(2,  16,  16, 15, 15,  80, 1'b1, 45, 16, 1'b0); // widest window
    run_phase(1, 200, 256,  2,  1, 400, 1'b0, 55, 10, 1'b1);
    run_phase(6, 256, 300,  1, 15, 150, 1'b0, 55,  9, 1'b0);

    wait_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (grid.errors == 0 && grid.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Catch a hang on either channel.
  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Verification failed");
    $finish;
  end

endmodule

[filelist.f]
src/gbpp_pkg.sv
src/gbpp_ctrl.sv
src/gbpp_dp.sv
src/grid_binned_point_picker_core.sv
src/gbpp_checker.sv
tb/grid_binned_point_picker_core_test.sv
